[rtl/assert_macros.svh]
// Assertion macros for the RTL file that carries checks, the top level.
// Depends on nothing; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NEVER(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/sscsc_pkg.sv]
// Shared constants, types and codes of the servo command slew controller.
// Depends on nothing; every RTL module imports it.
package sscsc_pkg;

    localparam int NUM_SERVOS  = 6;
    localparam int SERVO_W     = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam int GROUP_WIDTH = 3;
    localparam int POS_W       = 14;
    localparam int STEP_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int SLOT_W      = 3;
    localparam int TICK_W      = 4;
    localparam int IDX_OUT_W   = 3;
    localparam int CFG_IDX_W   = 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] CHAR_POS    = 8'h50;
    localparam logic [BYTE_W-1:0] CHAR_RATE   = 8'h52;
    localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0d;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_PROMPT = 8'h3e;

    localparam logic [POS_W-1:0]  START_POS      = 14'd4500;
    localparam logic [POS_W-1:0]  PULSE_MIN_RST  = 14'd2000;
    localparam logic [POS_W-1:0]  PULSE_MAX_RST  = 14'd10000;
    localparam logic [POS_W-1:0]  STEP_LIMIT     = 14'd255;
    localparam logic [TICK_W-1:0] SERVO_COUNT    = TICK_W'(NUM_SERVOS);
    localparam logic [TICK_W-1:0] SERVO_LAST     = TICK_W'(NUM_SERVOS - 1);
    localparam logic [TICK_W-1:0] GROUP1_BASE    = TICK_W'(GROUP_WIDTH);

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_MAX = 1'b1;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_PULSE = 1'b1;

    typedef struct packed {
        logic               is_tick;
        logic               group;
        logic [BYTE_W-1:0]  rx_byte;
        logic               done;
        logic               wr_valid;
        logic               wr_rate;
        logic [DIGIT_W-1:0] servo;
        logic [POS_W-1:0]   value;
    } t_op;

    typedef struct packed {
        logic [POS_W-1:0] pulse_min;
        logic [POS_W-1:0] pulse_max;
    } t_cfg;

    typedef struct packed {
        logic                 out_kind;
        logic [BYTE_W-1:0]    tx_byte;
        logic [IDX_OUT_W-1:0] servo_index;
        logic [POS_W-1:0]     pulse_width;
        logic                 last;
    } t_res;

endpackage

[rtl/sscsc_front.sv]
// Front end: accepts input beats, parses the serial command stream and
// classifies each beat into a back-end operation. Depends on sscsc_pkg.
module sscsc_front
    import sscsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_kind,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_group,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_op               o_q_data
);

    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic               r_is_rate, n_is_rate;
    logic [DIGIT_W-1:0] r_servo, n_servo;
    logic [POS_W-1:0]   r_value, n_value;

    logic               accept;
    logic [BYTE_W-1:0]  digit;
    logic               is_digit;
    logic               done;
    logic [POS_W-1:0]   value_x10;
    logic [TICK_W-1:0]  tick_base;

    assign accept    = i_push && !i_q_full;
    assign digit     = i_rx_byte - CHAR_ZERO;
    assign is_digit  = (digit <= 8'd9);
    assign value_x10 = {r_value[POS_W-4:0], 3'b000} + {r_value[POS_W-2:0], 1'b0};
    assign tick_base = i_group ? GROUP1_BASE : '0;

    always_comb begin
        n_slot    = r_slot;
        n_is_rate = r_is_rate;
        n_servo   = r_servo;
        n_value   = r_value;
        done      = 1'b0;
        if (accept && i_kind == KIND_BYTE) begin
            case (r_slot)
                3'd0: begin
                    if (i_rx_byte == CHAR_POS || i_rx_byte == CHAR_RATE) begin
                        n_is_rate = (i_rx_byte == CHAR_RATE);
                        n_slot    = 3'd1;
                    end
                end
                3'd1: begin
                    if (is_digit) begin
                        n_servo = digit[DIGIT_W-1:0];
                        n_value = '0;
                        n_slot  = 3'd2;
                    end
                end
                3'd2, 3'd3, 3'd4, 3'd5: begin
                    if (is_digit) begin
                        n_value = value_x10 + {{(POS_W-DIGIT_W){1'b0}}, digit[DIGIT_W-1:0]};
                        n_slot  = r_slot + 3'd1;
                    end
                end
                3'd6: begin
                    if (i_rx_byte == CHAR_CR) begin
                        done   = 1'b1;
                        n_slot = 3'd0;
                    end
                end
                default: begin
                    n_slot = 3'd0;
                end
            endcase
        end
    end

    always_comb begin
        o_q_data          = '0;
        o_q_data.is_tick  = i_kind;
        o_q_data.group    = i_group;
        o_q_data.rx_byte  = i_rx_byte;
        o_q_data.done     = done;
        o_q_data.wr_valid = done && (r_servo < SERVO_COUNT);
        o_q_data.wr_rate  = r_is_rate;
        o_q_data.servo    = r_servo;
        o_q_data.value    = r_value;
    end

    // A tick for a group with no servos gives no result and is dropped here.
    assign o_q_push = accept && (i_kind == KIND_BYTE || tick_base < SERVO_COUNT);
    assign o_full   = i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_is_rate <= 1'b0;
            r_servo   <= '0;
            r_value   <= '0;
        end else begin
            r_slot    <= n_slot;
            r_is_rate <= n_is_rate;
            r_servo   <= n_servo;
            r_value   <= n_value;
        end
    end

endmodule

[rtl/sscsc_queue.sv]
// Short operation queue between the front end and the back end.
// Depends on sscsc_pkg for the entry type and depth.
module sscsc_queue
    import sscsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_op  o_data
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

[rtl/sscsc_back.sv]
// Back end runs queued ops, holds per-servo state, slews one servo per cycle
// while the result register has room, and drives it. Depends on sscsc_pkg.
module sscsc_back
    import sscsc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_q_empty,
    input  t_op  i_q_data,
    output logic o_q_pop,
    input  logic i_pop,
    output logic o_empty,
    output t_res o_res
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ECHO   = 2'd1;
    localparam logic [1:0] ST_PROMPT = 2'd2;
    localparam logic [1:0] ST_TICK   = 2'd3;

    logic [1:0]        r_state, n_state;
    t_op               r_op, n_op;
    logic [1:0]        r_j, n_j;
    logic              r_out_valid, n_out_valid;
    t_res              r_res, n_res;

    logic [POS_W-1:0]  r_tgt  [NUM_SERVOS];
    logic [STEP_W-1:0] r_step [NUM_SERVOS];
    logic [POS_W-1:0]  r_cur  [NUM_SERVOS];

    logic              slot_free;
    logic [TICK_W-1:0] tick_s;
    logic [SERVO_W-1:0] tick_idx;
    logic [SERVO_W-1:0] cmd_idx;
    logic              tick_last;
    logic [POS_W-1:0]  cur, tgt, st, up_diff, dn_diff, moved, slewed;
    logic              wr_cmd;
    logic              wr_slew;
    logic [POS_W-1:0]  tgt_value;
    logic [STEP_W-1:0] step_value;

    assign slot_free = !r_out_valid || i_pop;
    assign tick_s    = (r_op.group ? GROUP1_BASE : '0) + {{(TICK_W-2){1'b0}}, r_j};
    assign tick_idx  = tick_s[SERVO_W-1:0];
    assign cmd_idx   = r_op.servo[SERVO_W-1:0];
    assign tick_last = (r_j == 2'(GROUP_WIDTH - 1)) || (tick_s == SERVO_LAST);

    assign cur     = r_cur[tick_idx];
    assign tgt     = r_tgt[tick_idx];
    assign st      = {{(POS_W-STEP_W){1'b0}}, r_step[tick_idx]};
    assign up_diff = tgt - cur;
    assign dn_diff = cur - tgt;

    always_comb begin
        if (tgt > cur) begin
            moved = (up_diff > st) ? cur + st : tgt;
        end else if (tgt < cur) begin
            moved = (dn_diff > st) ? cur - st : tgt;
        end else begin
            moved = cur;
        end
        if (moved > i_cfg.pulse_max) begin
            moved = i_cfg.pulse_max;
        end
        if (moved < i_cfg.pulse_min) begin
            moved = i_cfg.pulse_min;
        end
        slewed = (st == '0) ? tgt : moved;
    end

    assign tgt_value  = (r_op.value < i_cfg.pulse_min) ? i_cfg.pulse_min : r_op.value;
    assign step_value = (r_op.value > STEP_LIMIT) ? {STEP_W{1'b1}} : r_op.value[STEP_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_j         = r_j;
        n_out_valid = r_out_valid && !i_pop;
        n_res       = r_res;
        o_q_pop     = 1'b0;
        wr_cmd      = 1'b0;
        wr_slew     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_data;
                    n_j     = '0;
                    n_state = i_q_data.is_tick ? ST_TICK : ST_ECHO;
                end
            end
            ST_ECHO: begin
                if (slot_free) begin
                    n_out_valid       = 1'b1;
                    n_res             = '0;
                    n_res.out_kind    = KIND_BYTE;
                    n_res.tx_byte     = r_op.rx_byte;
                    n_res.last        = !r_op.done;
                    wr_cmd            = r_op.wr_valid;
                    n_state           = r_op.done ? ST_PROMPT : ST_IDLE;
                end
            end
            ST_PROMPT: begin
                if (slot_free) begin
                    n_out_valid       = 1'b1;
                    n_res             = '0;
                    n_res.out_kind    = KIND_BYTE;
                    n_res.tx_byte     = CHAR_PROMPT;
                    n_res.last        = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (slot_free) begin
                    n_out_valid       = 1'b1;
                    n_res             = '0;
                    n_res.out_kind    = KIND_PULSE;
                    n_res.servo_index = tick_s[IDX_OUT_W-1:0];
                    n_res.pulse_width = cur;
                    n_res.last        = tick_last;
                    wr_slew           = 1'b1;
                    n_j               = r_j + 2'd1;
                    n_state           = tick_last ? ST_IDLE : ST_TICK;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SERVOS; i++) begin
                r_tgt[i]  <= START_POS;
                r_step[i] <= '0;
                r_cur[i]  <= START_POS;
            end
        end else begin
            if (wr_cmd) begin
                if (r_op.wr_rate) begin
                    r_step[cmd_idx] <= step_value;
                end else begin
                    r_tgt[cmd_idx] <= tgt_value;
                end
            end
            if (wr_slew) begin
                r_cur[tick_idx] <= slewed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_res <= n_res;
    end

    assign o_empty = !r_out_valid;
    assign o_res   = r_res;

endmodule

[rtl/serial_servo_command_slew_controller_top.sv]
// Top level of the serial servo command slew controller: configuration
// registers, front end, operation queue and back end. Depends on sscsc_pkg
// and assert_macros.svh.

// Input beats are taken one per cycle into a two-entry operation queue while
// the queue has room; the back end then works one operation at a time. A
// received byte passes through the back end as a load step and an echo step,
// with a prompt step added when it completes a command. A tick takes a load
// step and then one step per servo of its group (three in a full group),
// because the back end reads and slews one servo's position, target and step
// per cycle while the output register has room. A tick for a group with no
// servos is dropped at the front and gives no result. Results wait in a
// one-beat output register; configuration writes take effect at the next edge.
`include "assert_macros.svh"
module serial_servo_command_slew_controller_top
    import sscsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_kind,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    input  logic                 i_group,
    output logic                 empty,
    input  logic                 pop,
    output logic                 o_out_kind,
    output logic [BYTE_W-1:0]    o_tx_byte,
    output logic [IDX_OUT_W-1:0] o_servo_index,
    output logic [POS_W-1:0]     o_pulse_width,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [POS_W-1:0]     i_cfg_data
);

    t_cfg r_cfg, n_cfg;
    logic q_push, q_full, q_pop, q_empty;
    t_op  q_wr_data, q_rd_data;
    t_res res;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PULSE_MIN: n_cfg.pulse_min = i_cfg_data;
                REG_PULSE_MAX: n_cfg.pulse_max = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_min <= PULSE_MIN_RST;
            r_cfg.pulse_max <= PULSE_MAX_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    sscsc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_kind    (i_kind),
        .i_rx_byte (i_rx_byte),
        .i_group   (i_group),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_q_data  (q_wr_data)
    );

    sscsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    sscsc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_rd_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (res)
    );

    assign o_out_kind    = res.out_kind;
    assign o_tx_byte     = res.tx_byte;
    assign o_servo_index = res.servo_index;
    assign o_pulse_width = res.pulse_width;
    assign o_last        = res.last;

    // A byte beat that is not the last of its item can only be the echo of CR.
    `ASSERT_IMPLIES(a_cr_before_prompt, i_clk, i_rst_n,
        !empty && o_out_kind == KIND_BYTE && !o_last, o_tx_byte == CHAR_CR)
    // Pulse beats only ever name servos that exist.
    `ASSERT_IMPLIES(a_servo_in_range, i_clk, i_rst_n,
        !empty && o_out_kind == KIND_PULSE, o_servo_index < IDX_OUT_W'(NUM_SERVOS))
    // The third servo of a group always closes its tick.
    `ASSERT_NEVER(a_group_end_last, i_clk, i_rst_n,
        !empty && o_out_kind == KIND_PULSE && !o_last
        && (o_servo_index == 3'd2 || o_servo_index == 3'd5))

endmodule
